/* src/mtfr_pkg.sv */
package mtfr_pkg;

   localparam int ANGLE_FIRST = 3;
   localparam int ANGLE_COUNT = 8;
   localparam int COUNT_W = 6;
   localparam int ANGLE_W = 31;
   localparam int THRESH_W = 30;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [COUNT_W-1:0] MIN_FRAME = 6'd3;
   localparam logic [29:0] THRESH_RESET = 30'd10000;
   localparam logic [15:0] ANGLE_OFFSET = 16'd10000;
   localparam logic [13:0] ANGLE_SCALE = 14'd10000;

   typedef logic [ANGLE_COUNT-1:0][7:0] angle_bytes_type;

   typedef struct packed {
      angle_bytes_type    angle_bytes;
      logic [COUNT_W-1:0] frame_length;
   } hit_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // (H - 10000) * 10000 + (L - 10000), worked as H * 10000 + L - 100010000.
   function automatic logic signed [ANGLE_W-1:0] decode_angle(input logic [15:0] h,
                                                               input logic [15:0] l);
      logic [29:0]        hs;
      logic signed [31:0] sum;
      hs  = 30'(h) * 30'(ANGLE_SCALE);
      sum = $signed({2'b00, hs}) + $signed({16'h0000, l})
            - $signed(32'(32'(ANGLE_OFFSET) * 32'(ANGLE_SCALE) + 32'(ANGLE_OFFSET)));
      return sum[ANGLE_W-1:0];
   endfunction

endpackage

/* src/modbus_tilt_frame_receiver_core.sv */
// Receives Modbus RTU bytes, one per req beat, keeps a CRC-16 over the frame and gives one
// rsp beat for every frame whose last two bytes carry its CRC, with the X and Y tilt decoded
// from frame bytes 3 to 10 and a flag for a change beyond csr threshold since the last frame.
// A byte is taken in every cycle while req_tready is high; the frame a byte closes passes
// through the CRC hit, angle decode and change compare registers, and a stall on rsp holds it.

module modbus_tilt_frame_receiver_core #(
   parameter int MAX_FRAME = 36
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // angle_x [30:0], angle_y [61:31], frame_length [67:62]
   output logic        rsp_tuser,   // over_threshold

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [29:0] csr_data     // tilt_threshold
);

   localparam int AW = mtfr_pkg::ANGLE_W;
   localparam int CW = mtfr_pkg::COUNT_W;

   logic              hit_valid;
   mtfr_pkg::hit_type hit;

   logic              out_ready, s2_ready, s1_ready;

   logic              s1_valid_ff, s1_valid_in;
   mtfr_pkg::hit_type s1_hit_ff;

   logic                 s2_valid_ff, s2_valid_in;
   logic signed [AW-1:0] s2_x_ff, s2_y_ff;
   logic [CW-1:0]        s2_len_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [AW-1:0] rsp_x_ff, rsp_y_ff;
   logic [CW-1:0]        rsp_len_ff;
   logic                 rsp_over_ff;

   logic signed [AW-1:0] prev_x_ff, prev_y_ff;
   logic [29:0]          threshold_ff;

   logic signed [31:0] diff_x, diff_y;
   logic [31:0]        abs_x, abs_y;
   logic               over;

   mtfr_frame_check #(.MAX_FRAME(MAX_FRAME)) u_frame_check (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid && req_tready),
      .rx_byte    (req_tdata),
      .hit_valid  (hit_valid),
      .hit        (hit)
   );

   always_comb begin
      out_ready    = !rsp_valid_ff || rsp_tready;
      s2_ready     = !s2_valid_ff || out_ready;
      s1_ready     = !s1_valid_ff || s2_ready;
      req_tready   = s1_ready;
      csr_ready    = 1'b1;

      s1_valid_in  = s1_ready ? hit_valid : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;

      diff_x = 32'(s2_x_ff) - 32'(prev_x_ff);
      diff_y = 32'(s2_y_ff) - 32'(prev_y_ff);
      abs_x  = diff_x[31] ? 32'(-diff_x) : 32'(diff_x);
      abs_y  = diff_y[31] ? 32'(-diff_y) : 32'(diff_y);
      over   = (abs_x > {2'b00, threshold_ff}) || (abs_y > {2'b00, threshold_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         threshold_ff <= mtfr_pkg::THRESH_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
         if (out_ready && s2_valid_ff) begin
            prev_x_ff <= s2_x_ff;
            prev_y_ff <= s2_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && hit_valid) begin
         s1_hit_ff <= hit;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_x_ff   <= mtfr_pkg::decode_angle({s1_hit_ff.angle_bytes[0], s1_hit_ff.angle_bytes[1]},
                                             {s1_hit_ff.angle_bytes[2], s1_hit_ff.angle_bytes[3]});
         s2_y_ff   <= mtfr_pkg::decode_angle({s1_hit_ff.angle_bytes[4], s1_hit_ff.angle_bytes[5]},
                                             {s1_hit_ff.angle_bytes[6], s1_hit_ff.angle_bytes[7]});
         s2_len_ff <= s1_hit_ff.frame_length;
      end
      if (out_ready && s2_valid_ff) begin
         rsp_x_ff    <= s2_x_ff;
         rsp_y_ff    <= s2_y_ff;
         rsp_len_ff  <= s2_len_ff;
         rsp_over_ff <= over;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_len_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_over_ff;

   a_stall_holds_s2 : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_ready |=> s2_valid_ff)
      else $error("decode stage dropped a result during a stall");

   a_ready_only_when_room : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff)
      else $error("input stalled while the pipeline had room");

   a_length_sane : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_len_ff >= mtfr_pkg::MIN_FRAME)
      else $error("result carries a frame shorter than the minimum");

   a_prev_follows : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && out_ready |=> prev_x_ff == rsp_x_ff && prev_y_ff == rsp_y_ff)
      else $error("previous angles not taken from the delivered result");

endmodule

/* src/mtfr_frame_check.sv */
module mtfr_frame_check #(
   parameter int MAX_FRAME = 36
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          rx_byte,
   output logic                hit_valid,
   output mtfr_pkg::hit_type   hit
);

   localparam logic [mtfr_pkg::COUNT_W-1:0] MaxCount = mtfr_pkg::COUNT_W'(MAX_FRAME);

   logic [mtfr_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]                  crc_running_ff, crc_running_in;
   logic [15:0]                  crc_one_back_ff, crc_one_back_in;
   logic [7:0]                   last_byte_ff, last_byte_in;
   mtfr_pkg::angle_bytes_type    angle_bytes_ff, angle_bytes_in;

   logic [mtfr_pkg::COUNT_W-1:0] count;
   logic                         match;
   logic                         restart;

   always_comb begin
      count          = byte_count_ff + 1'b1;
      match          = (count >= mtfr_pkg::MIN_FRAME) &&
                       (last_byte_ff == crc_one_back_ff[7:0]) &&
                       (rx_byte == crc_one_back_ff[15:8]);
      restart        = match || (count >= MaxCount);

      byte_count_in   = byte_count_ff;
      crc_running_in  = crc_running_ff;
      crc_one_back_in = crc_one_back_ff;
      last_byte_in    = last_byte_ff;
      angle_bytes_in  = angle_bytes_ff;

      if (byte_valid) begin
         if (byte_count_ff == '0) begin
            angle_bytes_in = '0;
         end
         for (int i = 0; i < mtfr_pkg::ANGLE_COUNT; i++) begin
            if (byte_count_ff == mtfr_pkg::COUNT_W'(mtfr_pkg::ANGLE_FIRST + i)) begin
               angle_bytes_in[i] = rx_byte;
            end
         end
         last_byte_in = rx_byte;
         if (restart) begin
            byte_count_in   = '0;
            crc_running_in  = mtfr_pkg::CRC_INIT;
            crc_one_back_in = mtfr_pkg::CRC_INIT;
         end else begin
            byte_count_in   = count;
            crc_one_back_in = crc_running_ff;
            crc_running_in  = mtfr_pkg::crc_feed(crc_running_ff, rx_byte);
         end
      end

      hit_valid        = byte_valid && match;
      hit.angle_bytes  = angle_bytes_in;
      hit.frame_length = count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         crc_running_ff  <= mtfr_pkg::CRC_INIT;
         crc_one_back_ff <= mtfr_pkg::CRC_INIT;
         last_byte_ff    <= '0;
         angle_bytes_ff  <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         crc_running_ff  <= crc_running_in;
         crc_one_back_ff <= crc_one_back_in;
         last_byte_ff    <= last_byte_in;
         angle_bytes_ff  <= angle_bytes_in;
      end
   end

   a_count_below_max : assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < MaxCount)
      else $error("byte count reached the frame limit");

   a_match_restarts : assert property (@(posedge clock) disable iff (reset)
      hit_valid |=> (byte_count_ff == '0) && (crc_running_ff == mtfr_pkg::CRC_INIT))
      else $error("frame state not restarted after a match");

endmodule

/* tb/sv/tilt_frame_checker.sv */
`timescale 1ns / 1ps

package tilt_tb_pkg;

   localparam int TILT_OFFSET = 10000;
   localparam int TILT_SCALE = 10000;

   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {8'h00, data};
      repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

endpackage

module tilt_frame_checker #(
   parameter int MAX_FRAME = 36
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [29:0] csr_data,
   output int          failures,
   output int          pending,
   output int          frames_predicted,
   output int          results_checked,
   output logic [5:0]  frame_pos
);

   localparam int AW = mtfr_pkg::ANGLE_W;
   localparam int CW = mtfr_pkg::COUNT_W;
   localparam int FIRST = mtfr_pkg::ANGLE_FIRST;
   localparam int COUNT = mtfr_pkg::ANGLE_COUNT;

   typedef struct {
      logic signed [AW-1:0] x;
      logic signed [AW-1:0] y;
      logic                 over;
      logic [CW-1:0]        len;
   } tilt_report_type;

   tilt_report_type expected_reports[$];

   logic [29:0] tilt_limit;
   logic [15:0] crc_run, crc_one, crc_two;
   logic [7:0]  last_two [2];
   logic [7:0]  angle_buf [COUNT];
   int          prev_x, prev_y;

   initial begin
      failures = 0;
      pending = 0;
      frames_predicted = 0;
      results_checked = 0;
      frame_pos = '0;
   end

   function automatic int tilt_decode(input logic [7:0] hh, input logic [7:0] hl,
                                      input logic [7:0] lh, input logic [7:0] ll);
      int hi, lo;
      hi = {16'h0000, hh, hl};
      lo = {16'h0000, lh, ll};
      return (hi - tilt_tb_pkg::TILT_OFFSET) * tilt_tb_pkg::TILT_SCALE
             + (lo - tilt_tb_pkg::TILT_OFFSET);
   endfunction

   task automatic restart_frame();
      frame_pos = '0;
      crc_run = mtfr_pkg::CRC_INIT;
      crc_one = mtfr_pkg::CRC_INIT;
      crc_two = mtfr_pkg::CRC_INIT;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      int              cnt, x, y;
      longint          dx, dy, lim;
      tilt_report_type rep;
      if (frame_pos == 0) angle_buf = '{default: 8'h00};
      if (frame_pos >= FIRST && frame_pos < FIRST + COUNT) angle_buf[frame_pos - FIRST] = b;
      last_two[0] = last_two[1];
      last_two[1] = b;
      crc_two = crc_one;
      crc_one = crc_run;
      crc_run = tilt_tb_pkg::modbus_crc_byte(crc_run, b);
      cnt = frame_pos + 1;
      frame_pos = cnt[5:0];
      // The two bytes just taken must carry the CRC of everything before them, low byte first.
      if (cnt >= 3 && last_two[0] == crc_two[7:0] && last_two[1] == crc_two[15:8]) begin
         x = tilt_decode(angle_buf[0], angle_buf[1], angle_buf[2], angle_buf[3]);
         y = tilt_decode(angle_buf[4], angle_buf[5], angle_buf[6], angle_buf[7]);
         dx = longint'(x) - longint'(prev_x);
         dy = longint'(y) - longint'(prev_y);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         lim = {34'd0, tilt_limit};
         rep.x = x[AW-1:0];
         rep.y = y[AW-1:0];
         rep.over = (dx > lim) || (dy > lim);
         rep.len = cnt[CW-1:0];
         expected_reports.push_back(rep);
         frames_predicted++;
         prev_x = x;
         prev_y = y;
         restart_frame();
      end else if (cnt >= MAX_FRAME) begin
         restart_frame();
      end
   endtask

   task automatic check_report();
      tilt_report_type      e;
      logic signed [AW-1:0] ax, ay;
      logic [CW-1:0]        alen;
      if (expected_reports.size() == 0) begin
         $error("rsp beat with no frame awaiting it: tdata %h, tuser %b", rsp_tdata, rsp_tuser);
         failures++;
         return;
      end
      e = expected_reports.pop_front();
      results_checked++;
      ax = rsp_tdata[0 +: AW];
      ay = rsp_tdata[AW +: AW];
      alen = rsp_tdata[2*AW +: CW];
      if (ax !== e.x) begin
         $error("angle_x: expected %0d, actual %0d", e.x, ax);
         failures++;
      end
      if (ay !== e.y) begin
         $error("angle_y: expected %0d, actual %0d", e.y, ay);
         failures++;
      end
      if (rsp_tuser !== e.over) begin
         $error("over_threshold: expected %0b, actual %0b", e.over, rsp_tuser);
         failures++;
      end
      if (alen !== e.len) begin
         $error("frame_length: expected %0d, actual %0d", e.len, alen);
         failures++;
      end
      if (rsp_tdata[71:2*AW+CW] !== '0) begin
         $error("tdata padding: expected 0, actual %h", rsp_tdata[71:2*AW+CW]);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tilt_limit = mtfr_pkg::THRESH_RESET;
         restart_frame();
         last_two = '{default: 8'h00};
         angle_buf = '{default: 8'h00};
         prev_x = 0;
         prev_y = 0;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) tilt_limit = csr_data;
         if (rsp_tvalid && rsp_tready) check_report();
         if (req_tvalid && req_tready) predict_byte(req_tdata);
      end
      pending = expected_reports.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int MAX_FRAME = 36;
   localparam int PHASE_BYTES = 100;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [29:0] csr_data;

   int          failures, pending, frames_predicted, results_checked;
   logic [5:0]  frame_pos;

   int          send_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          hold_requests = 0;
   int          bytes_sent = 0;
   logic [29:0] tilt_limit_now = mtfr_pkg::THRESH_RESET;
   logic [15:0] last_words [4];
   logic [7:0]  frame_bytes [$];

   always #5 clock = ~clock;

   modbus_tilt_frame_receiver_core #(.MAX_FRAME(MAX_FRAME)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tilt_frame_checker #(.MAX_FRAME(MAX_FRAME)) frame_watch (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .failures         (failures),
      .pending          (pending),
      .frames_predicted (frames_predicted),
      .results_checked  (results_checked),
      .frame_pos        (frame_pos)
   );

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame_bytes();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // Filler bytes until the block is expected to stand at the start of a frame.
   task automatic realign();
      while (frame_pos != 0) send_byte(8'($urandom));
   endtask

   task automatic build_frame(input int len, input logic [15:0] w [4]);
      logic [15:0] crc;
      logic [7:0]  b;
      frame_bytes.delete();
      crc = mtfr_pkg::CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
         if (i == 1) b = 8'h04;
         else if (i == 2) b = 8'h08;
         else if (i >= 3 && i < 11)
            b = ((i - 3) % 2 == 0) ? w[(i - 3) / 2][15:8] : w[(i - 3) / 2][7:0];
         else b = 8'($urandom);
         crc = tilt_tb_pkg::modbus_crc_byte(crc, b);
         frame_bytes.push_back(b);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
   endtask

   function automatic logic [15:0] nudge(input logic [15:0] v, input int d);
      int t;
      t = int'(v) + d;
      if (t < 0 || t > 65535) return 16'($urandom);
      return t[15:0];
   endfunction

   task automatic write_threshold(input logic [29:0] v);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      tilt_limit_now = v;
   endtask

   task automatic random_burst(input bit short_frames);
      logic [15:0] w [4];
      int          len, pick, d, idx;
      w = last_words;
      pick = $urandom_range(99);
      if (pick < 65) begin
         if (short_frames) len = $urandom_range(3, 5);
         else if ($urandom_range(99) < 70) len = 13;
         else len = $urandom_range(3, MAX_FRAME);
         if ($urandom_range(1)) begin
            foreach (w[k]) w[k] = 16'($urandom);
         end else begin
            // Small steps, some of them landing exactly on the threshold or just past it.
            case ($urandom_range(4))
               0: d = int'(tilt_limit_now);
               1: d = int'(tilt_limit_now) + 1;
               2: d = -int'(tilt_limit_now);
               3: d = -int'(tilt_limit_now) - 1;
               default: d = int'($urandom_range(40000)) - 20000;
            endcase
            w[1] = nudge(w[1], d);
            w[3] = nudge(w[3], $urandom_range(1) ? 0 : int'($urandom_range(40000)) - 20000);
         end
         realign();
         build_frame(len, w);
         send_frame_bytes();
         if (len >= 13) last_words = w;
      end else if (pick < 80) begin
         foreach (w[k]) w[k] = 16'($urandom);
         realign();
         build_frame($urandom_range(3, MAX_FRAME), w);
         if ($urandom_range(1)) begin
            idx = $urandom_range(frame_bytes.size() - 1);
            frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
         end else begin
            void'(frame_bytes.pop_back());
         end
         send_frame_bytes();
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end else begin
         realign();
         repeat ($urandom_range(MAX_FRAME + 1, MAX_FRAME + 9)) send_byte(8'($urandom));
      end
   endtask

   initial begin
      int hold_left, hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   initial begin
      logic [15:0] w [4];
      logic [29:0] limit;
      int          phase_end;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_valid = 1'b0;
      csr_data = '0;
      last_words = '{default: 16'h0000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A zero threshold: the second minimal frame repeats the first, so its change is
      // exactly equal to the threshold and must not be flagged.
      write_threshold('0);
      w = '{default: 16'h0000};
      build_frame(3, w);
      send_frame_bytes();
      build_frame(3, w);
      send_frame_bytes();
      w = '{default: 16'hFFFF};
      build_frame(13, w);
      send_frame_bytes();
      last_words = w;
      send_byte(8'hFF);
      send_byte(8'hFF);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               rx_stall_pct = 0;
               limit = 30'($urandom_range(1, 40000));
            end
            1: begin
               send_idle_pct = 87;
               rx_stall_pct = 0;
               limit = 30'd1000000000;
            end
            2: begin
               send_idle_pct = 0;
               rx_stall_pct = 87;
               limit = 30'h1FFFFFFF;
            end
            3: begin
               send_idle_pct = 30;
               rx_stall_pct = 30;
               limit = 30'($urandom_range(0, 1000000000));
            end
            default: begin
               send_idle_pct = 0;
               rx_stall_pct = 0;
               limit = 30'($urandom_range(0, 20000));
            end
         endcase
         write_threshold(limit);
         if (p == 4) hold_requests++;
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end || (p == 4 && frames_predicted < 40))
            random_burst(p == 4);
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes in five idling phases, thresholds from zero to the top of range.",
               bytes_sent);
      $display("Frames expected: %0d, result beats checked: %0d.",
               frames_predicted, results_checked);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still awaited.", pending);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* modbus_tilt_frame_receiver_core.f */
src/mtfr_pkg.sv
src/mtfr_frame_check.sv
src/modbus_tilt_frame_receiver_core.sv
tb/sv/tilt_frame_checker.sv
tb/sv/tb.sv
